>>> design/pdp_pkg.sv
package pdp_pkg;

  localparam int MaxParticles = 1024;
  localparam int SlotW        = 10;
  localparam int PosW         = 24;
  localparam int KindW        = 2;
  localparam int CountW       = 11;
  localparam int RadiusW      = 23;
  localparam int DensW        = 24;
  localparam int PressW       = 32;
  localparam int CfgDataW     = 32;
  localparam int IterW        = 6;

  // Iterations of the root and divide loops, minus one.
  localparam logic [IterW-1:0] SqrtLast = 6'd30;
  localparam logic [IterW-1:0] DivLast  = 6'd46;

  typedef enum logic [1:0] {
    CFG_RADIUS    = 2'd0,
    CFG_REF_DENS  = 2'd1,
    CFG_GAIN      = 2'd2,
    CFG_COUNT     = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_QUERY = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SELF,
    S_RD,
    S_CHK,
    S_SQ,
    S_D2,
    S_CMP,
    S_SQRT,
    S_DCHK,
    S_DIV,
    S_ACC,
    S_PMUL,
    S_POUT
  } state_t;

  typedef struct packed {
    logic mem_we;
    logic rd_self;
    logic latch_self;
    logic k_inc;
    logic load_diff;
    logic load_sq;
    logic load_d2;
    logic sqrt_init;
    logic sqrt_step;
    logic div_init;
    logic div_step;
    logic acc;
    logic pmul;
    logic out_fire;
    logic out_ghost;
  } cmd_t;

  typedef struct packed {
    logic self_ghost;
    logic k_done;
    logic nb_skip;
    logic in_range;
    logic dist_zero;
  } stat_t;

endpackage

>>> design/particle_density_pressure_unit.sv
// Particle number density and pressure unit.
// Input items arrive on start with in_opcode, in_slot, in_pos_x/y/z and in_kind,
// and are taken when start is high and busy is low. A load item writes the
// particle into its slot and never raises busy, so loads can
// stream at one item per cycle. A query item raises busy and walks slots
// 0 .. min(particle_count, 1024)-1 against the queried particle.
// Per walked slot, a skipped slot (itself or a ghost) is only read and
// checked; a slot outside the radius also has its distance squared formed and
// compared; a coincident neighbor also runs the bit-serial root unit, and any
// other neighbor then runs the restoring divider as well; the root and divide
// loops dominate. After the walk the pressure is formed and the result shown.
// A ghost query answers right after its own slot is read, with no walk.
// Each result is shown for one cycle with out_valid high; the receiver
// cannot stall it, and a new item may be taken in that same cycle.
// Configuration writes (cfg_we, cfg_addr, cfg_wdata) land immediately and
// must only happen while busy is low. Synchronous reset clears control and
// the configuration but for the radius, which it sets to 44040; the particle
// store is not cleared and must be loaded before it is queried.
module particle_density_pressure_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_opcode,
  input  logic [pdp_pkg::SlotW-1:0]       in_slot,
  input  logic signed [pdp_pkg::PosW-1:0] in_pos_x,
  input  logic signed [pdp_pkg::PosW-1:0] in_pos_y,
  input  logic signed [pdp_pkg::PosW-1:0] in_pos_z,
  input  logic [pdp_pkg::KindW-1:0]       in_kind,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_addr,
  input  logic [pdp_pkg::CfgDataW-1:0]    cfg_wdata,
  output logic                            out_valid,
  output logic [pdp_pkg::SlotW-1:0]       out_queried_slot,
  output logic [pdp_pkg::DensW-1:0]       out_number_density,
  output logic [pdp_pkg::PressW-1:0]      out_pressure,
  output logic                            out_is_ghost
);

  // Commands from the sequencer, status back from the datapath.
  pdp_pkg::cmd_t  cmd;
  pdp_pkg::stat_t stat;

  pdp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_opcode (in_opcode),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy)
  );

  pdp_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .stat               (stat),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .in_slot            (in_slot),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pos_z           (in_pos_z),
    .in_kind            (in_kind),
    .out_valid          (out_valid),
    .out_queried_slot   (out_queried_slot),
    .out_number_density (out_number_density),
    .out_pressure       (out_pressure),
    .out_is_ghost       (out_is_ghost)
  );

endmodule

>>> design/pdp_ctrl.sv
module pdp_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic            in_opcode,
  input  pdp_pkg::stat_t  stat,
  output pdp_pkg::cmd_t   cmd,
  output logic            busy
);

  pdp_pkg::state_t             state_r, state_nxt;
  logic [pdp_pkg::IterW-1:0]   iter_r, iter_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pdp_pkg::S_IDLE;
      iter_r  <= '0;
    end else begin
      state_r <= state_nxt;
      iter_r  <= iter_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    iter_nxt  = iter_r;
    cmd       = '0;
    busy      = (state_r != pdp_pkg::S_IDLE);
    unique case (state_r)
      pdp_pkg::S_IDLE: begin
        if (start) begin
          if (pdp_pkg::op_t'(in_opcode) == pdp_pkg::OP_QUERY) begin
            cmd.rd_self = 1'b1;
            state_nxt   = pdp_pkg::S_SELF;
          end else begin
            cmd.mem_we = 1'b1;
          end
        end
      end
      pdp_pkg::S_SELF: begin
        cmd.latch_self = 1'b1;
        if (stat.self_ghost) begin
          cmd.out_fire  = 1'b1;
          cmd.out_ghost = 1'b1;
          state_nxt     = pdp_pkg::S_IDLE;
        end else begin
          state_nxt = pdp_pkg::S_RD;
        end
      end
      pdp_pkg::S_RD: begin
        state_nxt = stat.k_done ? pdp_pkg::S_PMUL : pdp_pkg::S_CHK;
      end
      pdp_pkg::S_CHK: begin
        if (stat.nb_skip) begin
          cmd.k_inc = 1'b1;
          state_nxt = pdp_pkg::S_RD;
        end else begin
          cmd.load_diff = 1'b1;
          state_nxt     = pdp_pkg::S_SQ;
        end
      end
      pdp_pkg::S_SQ: begin
        cmd.load_sq = 1'b1;
        state_nxt   = pdp_pkg::S_D2;
      end
      pdp_pkg::S_D2: begin
        cmd.load_d2 = 1'b1;
        state_nxt   = pdp_pkg::S_CMP;
      end
      pdp_pkg::S_CMP: begin
        if (stat.in_range) begin
          cmd.sqrt_init = 1'b1;
          iter_nxt      = pdp_pkg::SqrtLast;
          state_nxt     = pdp_pkg::S_SQRT;
        end else begin
          cmd.k_inc = 1'b1;
          state_nxt = pdp_pkg::S_RD;
        end
      end
      pdp_pkg::S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        iter_nxt      = iter_r - 1'b1;
        if (iter_r == '0) state_nxt = pdp_pkg::S_DCHK;
      end
      pdp_pkg::S_DCHK: begin
        if (stat.dist_zero) begin
          state_nxt = pdp_pkg::S_ACC;
        end else begin
          cmd.div_init = 1'b1;
          iter_nxt     = pdp_pkg::DivLast;
          state_nxt    = pdp_pkg::S_DIV;
        end
      end
      pdp_pkg::S_DIV: begin
        cmd.div_step = 1'b1;
        iter_nxt     = iter_r - 1'b1;
        if (iter_r == '0) state_nxt = pdp_pkg::S_ACC;
      end
      pdp_pkg::S_ACC: begin
        cmd.acc   = 1'b1;
        cmd.k_inc = 1'b1;
        state_nxt = pdp_pkg::S_RD;
      end
      pdp_pkg::S_PMUL: begin
        cmd.pmul  = 1'b1;
        state_nxt = pdp_pkg::S_POUT;
      end
      pdp_pkg::S_POUT: begin
        cmd.out_fire = 1'b1;
        state_nxt    = pdp_pkg::S_IDLE;
      end
      default: state_nxt = pdp_pkg::S_IDLE;
    endcase
  end

endmodule

>>> design/pdp_datapath.sv
module pdp_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pdp_pkg::cmd_t                 cmd,
  output pdp_pkg::stat_t                stat,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_addr,
  input  logic [pdp_pkg::CfgDataW-1:0]  cfg_wdata,
  input  logic [pdp_pkg::SlotW-1:0]     in_slot,
  input  logic signed [pdp_pkg::PosW-1:0] in_pos_x,
  input  logic signed [pdp_pkg::PosW-1:0] in_pos_y,
  input  logic signed [pdp_pkg::PosW-1:0] in_pos_z,
  input  logic [pdp_pkg::KindW-1:0]     in_kind,
  output logic                          out_valid,
  output logic [pdp_pkg::SlotW-1:0]     out_queried_slot,
  output logic [pdp_pkg::DensW-1:0]     out_number_density,
  output logic [pdp_pkg::PressW-1:0]    out_pressure,
  output logic                          out_is_ghost
);

  localparam int EntryW = 3*pdp_pkg::PosW + pdp_pkg::KindW;
  localparam logic [pdp_pkg::DensW-1:0] DensMax = '1;
  localparam logic [pdp_pkg::PressW-1:0] PressMax = '1;

  // Configuration registers.
  logic [pdp_pkg::RadiusW-1:0] radius_r;
  logic [pdp_pkg::DensW-1:0]   ref_dens_r;
  logic [pdp_pkg::PressW-1:0]  gain_r;
  logic [pdp_pkg::CountW-1:0]  count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= 23'd44040;
      ref_dens_r <= '0;
      gain_r     <= '0;
      count_r    <= '0;
    end else if (cfg_we) begin
      unique case (pdp_pkg::cfg_idx_t'(cfg_addr))
        pdp_pkg::CFG_RADIUS:   radius_r   <= cfg_wdata[pdp_pkg::RadiusW-1:0];
        pdp_pkg::CFG_REF_DENS: ref_dens_r <= cfg_wdata[pdp_pkg::DensW-1:0];
        pdp_pkg::CFG_GAIN:     gain_r     <= cfg_wdata[pdp_pkg::PressW-1:0];
        pdp_pkg::CFG_COUNT:    count_r    <= cfg_wdata[pdp_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  // Particle store: one write port, one registered read port.
  logic [EntryW-1:0] mem [pdp_pkg::MaxParticles];
  logic [EntryW-1:0] rd_q;
  logic [pdp_pkg::CountW-1:0] k_r;
  logic [pdp_pkg::SlotW-1:0]  rd_addr;

  assign rd_addr = cmd.rd_self ? in_slot : k_r[pdp_pkg::SlotW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.mem_we) mem[in_slot] <= {in_pos_x, in_pos_y, in_pos_z, in_kind};
    rd_q <= mem[rd_addr];
  end

  logic signed [pdp_pkg::PosW-1:0] rx, ry, rz;
  logic [pdp_pkg::KindW-1:0] rkind;
  assign {rx, ry, rz, rkind} = rd_q;

  // Queried particle.
  logic [pdp_pkg::SlotW-1:0]       slot_r;
  logic signed [pdp_pkg::PosW-1:0] sx_r, sy_r, sz_r;
  logic [45:0]                     r2_r;
  logic [pdp_pkg::CountW-1:0]      n_eff;

  always_ff @(posedge clk) begin
    if (cmd.rd_self) slot_r <= in_slot;
    if (cmd.latch_self) begin
      sx_r <= rx;
      sy_r <= ry;
      sz_r <= rz;
      r2_r <= radius_r * radius_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_self) k_r <= '0;
    else if (cmd.k_inc) k_r <= k_r + 1'b1;
  end

  assign n_eff = (count_r > pdp_pkg::CountW'(pdp_pkg::MaxParticles)) ?
                 pdp_pkg::CountW'(pdp_pkg::MaxParticles) : count_r;

  // Distance squared.
  logic [pdp_pkg::PosW:0] dx_r, dy_r, dz_r;
  logic [47:0] qx_r, qy_r, qz_r;
  logic [49:0] d2_r;

  function automatic logic [pdp_pkg::PosW:0] abs_diff(
    input logic signed [pdp_pkg::PosW-1:0] a,
    input logic signed [pdp_pkg::PosW-1:0] b
  );
    logic signed [pdp_pkg::PosW:0] d;
    begin
      d = {a[pdp_pkg::PosW-1], a} - {b[pdp_pkg::PosW-1], b};
      abs_diff = d[pdp_pkg::PosW] ? -d : d;
    end
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load_diff) begin
      dx_r <= abs_diff(rx, sx_r);
      dy_r <= abs_diff(ry, sy_r);
      dz_r <= abs_diff(rz, sz_r);
    end
    if (cmd.load_sq) begin
      qx_r <= 48'(dx_r * dx_r);
      qy_r <= 48'(dy_r * dy_r);
      qz_r <= 48'(dz_r * dz_r);
    end
    if (cmd.load_d2) d2_r <= 50'(qx_r) + 50'(qy_r) + 50'(qz_r);
  end

  // Square root of d2 * 2^16, two bits of the radicand per cycle.
  logic [61:0] srem_r, sres_r, sbit_r;
  logic [62:0] strial;
  assign strial = {1'b0, sres_r} + {1'b0, sbit_r};

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      srem_r <= {d2_r[45:0], 16'b0};
      sres_r <= '0;
      sbit_r <= 62'd1 << 60;
    end else if (cmd.sqrt_step) begin
      if ({1'b0, srem_r} >= strial) begin
        srem_r <= srem_r - strial[61:0];
        sres_r <= (sres_r >> 1) + sbit_r;
      end else begin
        sres_r <= sres_r >> 1;
      end
      sbit_r <= sbit_r >> 2;
    end
  end

  logic [30:0] root_len;
  assign root_len = sres_r[30:0];

  // Restoring divide of radius * 2^24 by the distance, one quotient bit per cycle.
  logic [46:0] quo_r;
  logic [30:0] drem_r;
  logic [31:0] dtrial;
  assign dtrial = {drem_r, quo_r[46]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      quo_r  <= {radius_r, 24'b0};
      drem_r <= '0;
    end else if (cmd.div_step) begin
      if (dtrial >= {1'b0, root_len}) begin
        drem_r <= 31'(dtrial - {1'b0, root_len});
        quo_r  <= {quo_r[45:0], 1'b1};
      end else begin
        drem_r <= dtrial[30:0];
        quo_r  <= {quo_r[45:0], 1'b0};
      end
    end
  end

  // Weight and density accumulation.
  logic [pdp_pkg::DensW-1:0] weight, dens_r;
  logic [46:0]               qm;
  logic [pdp_pkg::DensW:0]   dsum;

  always_comb begin
    qm = quo_r - 47'd65536;
    if (root_len == '0)          weight = DensMax;
    else if (quo_r <= 47'd65536) weight = '0;
    else if (qm > 47'(DensMax))  weight = DensMax;
    else                         weight = qm[pdp_pkg::DensW-1:0];
  end

  assign dsum = {1'b0, dens_r} + {1'b0, weight};

  always_ff @(posedge clk) begin
    if (cmd.latch_self) dens_r <= '0;
    else if (cmd.acc) dens_r <= dsum[pdp_pkg::DensW] ? DensMax : dsum[pdp_pkg::DensW-1:0];
  end

  // Pressure.
  logic [55:0] prod_r;
  logic [pdp_pkg::DensW-1:0] excess;
  assign excess = dens_r - ref_dens_r;

  always_ff @(posedge clk) begin
    if (cmd.pmul) prod_r <= (dens_r > ref_dens_r) ? 56'(excess * gain_r) : '0;
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= cmd.out_fire;
    if (cmd.out_fire) begin
      out_queried_slot <= slot_r;
      out_is_ghost     <= cmd.out_ghost;
      if (cmd.out_ghost) begin
        out_number_density <= '0;
        out_pressure       <= '0;
      end else begin
        out_number_density <= dens_r;
        out_pressure       <= (prod_r[55:48] != '0) ? PressMax : prod_r[47:16];
      end
    end
  end

  assign stat.self_ghost = rkind[1];
  assign stat.nb_skip    = (k_r[pdp_pkg::SlotW-1:0] == slot_r) || rkind[1];
  assign stat.k_done     = (k_r >= n_eff);
  assign stat.in_range   = (d2_r < {4'b0, r2_r});
  assign stat.dist_zero  = (root_len == '0);

endmodule

>>> tb/sv/pdp_checker.sv
module pdp_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic                            busy,
  input  logic                            in_opcode,
  input  logic [pdp_pkg::SlotW-1:0]       in_slot,
  input  logic signed [pdp_pkg::PosW-1:0] in_pos_x,
  input  logic signed [pdp_pkg::PosW-1:0] in_pos_y,
  input  logic signed [pdp_pkg::PosW-1:0] in_pos_z,
  input  logic [pdp_pkg::KindW-1:0]       in_kind,
  input  logic                            cfg_we,
  input  logic [1:0]                      cfg_addr,
  input  logic [pdp_pkg::CfgDataW-1:0]    cfg_wdata,
  input  logic                            out_valid,
  input  logic [pdp_pkg::SlotW-1:0]       out_queried_slot,
  input  logic [pdp_pkg::DensW-1:0]       out_number_density,
  input  logic [pdp_pkg::PressW-1:0]      out_pressure,
  input  logic                            out_is_ghost,
  output int                              fail_count,
  output int                              pending,
  output int                              results_seen
);
  import pdp_pkg::*;

  typedef struct {
    logic [SlotW-1:0]  slot;
    logic [DensW-1:0]  dens;
    logic [PressW-1:0] press;
    logic              ghost;
  } answer_t;

  localparam logic [63:0] DensSat  = 64'hFF_FFFF;
  localparam logic [63:0] PressSat = 64'hFFFF_FFFF;

  logic signed [PosW-1:0] pos_x [MaxParticles];
  logic signed [PosW-1:0] pos_y [MaxParticles];
  logic signed [PosW-1:0] pos_z [MaxParticles];
  logic [KindW-1:0]       kinds [MaxParticles];

  logic [RadiusW-1:0] radius_q;
  logic [DensW-1:0]   ref_dens_q;
  logic [PressW-1:0]  gain_q;
  logic [CountW-1:0]  count_q;

  answer_t answers_due [$];

  assign pending = answers_due.size();

  task automatic report(input string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    fail_count++;
  endtask

  function automatic logic [63:0] root64(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] axis_gap(input logic signed [PosW-1:0] a,
                                           input logic signed [PosW-1:0] b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? 64'(-d) : 64'(d);
  endfunction

  // Density is the saturating sum of radius/dist - 1 over live neighbors.
  function automatic answer_t pressure_at(input logic [SlotW-1:0] s);
    answer_t a;
    logic [63:0] r2, d2, root_len, q, w, dens, press, dx, dy, dz;
    int n;
    a.slot = s;
    a.dens = '0;
    a.press = '0;
    a.ghost = 1'b0;
    if (kinds[s][1]) begin
      a.ghost = 1'b1;
      return a;
    end
    r2 = 64'(radius_q) * 64'(radius_q);
    n = (count_q > MaxParticles) ? MaxParticles : int'(count_q);
    dens = 0;
    for (int k = 0; k < n; k++) begin
      if (k == int'(s) || kinds[k][1]) continue;
      dx = axis_gap(pos_x[k], pos_x[s]);
      dy = axis_gap(pos_y[k], pos_y[s]);
      dz = axis_gap(pos_z[k], pos_z[s]);
      d2 = dx * dx + dy * dy + dz * dz;
      if (d2 >= r2) continue;
      root_len = root64(d2 << 16);
      if (root_len == 0) begin
        w = DensSat;
      end else begin
        q = (64'(radius_q) << 24) / root_len;
        w = (q > 64'd65536) ? q - 64'd65536 : 64'd0;
        if (w > DensSat) w = DensSat;
      end
      dens = dens + w;
      if (dens > DensSat) dens = DensSat;
    end
    press = 0;
    if (dens > 64'(ref_dens_q)) begin
      press = ((dens - 64'(ref_dens_q)) * 64'(gain_q)) >> 16;
      if (press > PressSat) press = PressSat;
    end
    a.dens = dens[DensW-1:0];
    a.press = press[PressW-1:0];
    return a;
  endfunction

  initial begin
    fail_count = 0;
    results_seen = 0;
  end

  always @(posedge clk) begin
    answer_t want;
    if (!rst_n) begin
      radius_q <= 23'd44040;
      ref_dens_q <= '0;
      gain_q <= '0;
      count_q <= '0;
    end else begin
      // A result is compared before a query taken at the same edge is queued.
      if (out_valid) begin
        results_seen++;
        if (answers_due.size() == 0) begin
          report($sformatf("result for slot %0d with nothing expected", out_queried_slot));
        end else begin
          want = answers_due.pop_front();
          if (out_queried_slot !== want.slot)
            report($sformatf("slot got %0d want %0d", out_queried_slot, want.slot));
          if (out_number_density !== want.dens)
            report($sformatf("slot %0d density got %h want %h",
                             want.slot, out_number_density, want.dens));
          if (out_pressure !== want.press)
            report($sformatf("slot %0d pressure got %h want %h",
                             want.slot, out_pressure, want.press));
          if (out_is_ghost !== want.ghost)
            report($sformatf("slot %0d ghost flag got %b want %b",
                             want.slot, out_is_ghost, want.ghost));
        end
      end
      if (start && !busy) begin
        if (op_t'(in_opcode) == OP_LOAD) begin
          pos_x[in_slot] <= in_pos_x;
          pos_y[in_slot] <= in_pos_y;
          pos_z[in_slot] <= in_pos_z;
          kinds[in_slot] <= in_kind;
        end else begin
          answers_due = {answers_due, pressure_at(in_slot)};
        end
      end
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_addr))
          CFG_RADIUS:   radius_q <= cfg_wdata[RadiusW-1:0];
          CFG_REF_DENS: ref_dens_q <= cfg_wdata[DensW-1:0];
          CFG_GAIN:     gain_q <= cfg_wdata[PressW-1:0];
          CFG_COUNT:    count_q <= cfg_wdata[CountW-1:0];
          default: ;
        endcase
      end
    end
  end
endmodule

>>> tb/sv/tb.sv
// Top of the testbench for the particle density and pressure unit.
// This module only makes stimulus and gives the verdict; the checker beside
// the block mirrors the particle store and the registers, predicts each
// query's answer at the edge where the item is taken, and counts mismatches.
module tb;
  import pdp_pkg::*;

  logic                     clk;
  logic                     rst_n;
  logic                     start;
  logic                     busy;
  logic                     in_opcode;
  logic [SlotW-1:0]         in_slot;
  logic signed [PosW-1:0]   in_pos_x;
  logic signed [PosW-1:0]   in_pos_y;
  logic signed [PosW-1:0]   in_pos_z;
  logic [KindW-1:0]         in_kind;
  logic                     cfg_we;
  logic [1:0]               cfg_addr;
  logic [CfgDataW-1:0]      cfg_wdata;
  logic                     out_valid;
  logic [SlotW-1:0]         out_queried_slot;
  logic [DensW-1:0]         out_number_density;
  logic [PressW-1:0]        out_pressure;
  logic                     out_is_ghost;
  int                       fail_count;
  int                       pending;
  int                       results_seen;

  // Slots that hold a particle; a query must never read any other slot.
  bit written [MaxParticles];
  int loads_sent;
  int queries_sent;

  localparam int Cluster = 44040;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  particle_density_pressure_unit i_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_slot            (in_slot),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pos_z           (in_pos_z),
    .in_kind            (in_kind),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_queried_slot   (out_queried_slot),
    .out_number_density (out_number_density),
    .out_pressure       (out_pressure),
    .out_is_ghost       (out_is_ghost)
  );

  pdp_checker i_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .start              (start),
    .busy               (busy),
    .in_opcode          (in_opcode),
    .in_slot            (in_slot),
    .in_pos_x           (in_pos_x),
    .in_pos_y           (in_pos_y),
    .in_pos_z           (in_pos_z),
    .in_kind            (in_kind),
    .cfg_we             (cfg_we),
    .cfg_addr           (cfg_addr),
    .cfg_wdata          (cfg_wdata),
    .out_valid          (out_valid),
    .out_queried_slot   (out_queried_slot),
    .out_number_density (out_number_density),
    .out_pressure       (out_pressure),
    .out_is_ghost       (out_is_ghost),
    .fail_count         (fail_count),
    .pending            (pending),
    .results_seen       (results_seen)
  );

  // Mostly back-to-back items, often a short gap, now and then a long one.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // Presents one item and holds it until the unit takes it. The caller is
  // at a rising edge on entry and on return.
  task automatic send_item(input op_t op, input int slot, input int x, input int y,
                           input int z, input int kind, input int gap);
    in_opcode <= op;
    in_slot <= slot[SlotW-1:0];
    in_pos_x <= x[PosW-1:0];
    in_pos_y <= y[PosW-1:0];
    in_pos_z <= z[PosW-1:0];
    in_kind <= kind[KindW-1:0];
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (op == OP_LOAD) begin
      written[slot] = 1'b1;
      loads_sent++;
    end else begin
      queries_sent++;
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic load_at(input int slot, input int x, input int y, input int z,
                         input int kind);
    send_item(OP_LOAD, slot, x, y, z, kind, pick_gap());
  endtask

  task automatic query_at(input int slot);
    send_item(OP_QUERY, slot, 0, 0, 0, 0, pick_gap());
  endtask

  // Stops the sender until every expected result is back. Loads leave
  // nothing to wait for, so a few extra cycles cover the last one.
  task automatic drain();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all four registers on consecutive edges while the unit is idle.
  task automatic set_regs(input int unsigned radius, input int unsigned ref_dens,
                          input int unsigned gain, input int unsigned count);
    cfg_we <= 1'b1;
    cfg_addr <= CFG_RADIUS;
    cfg_wdata <= radius;
    @(posedge clk);
    cfg_addr <= CFG_REF_DENS;
    cfg_wdata <= ref_dens;
    @(posedge clk);
    cfg_addr <= CFG_GAIN;
    cfg_wdata <= gain;
    @(posedge clk);
    cfg_addr <= CFG_COUNT;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic int near(input int center, input int span);
    return center + $urandom_range(0, 2 * span) - span;
  endfunction

  function automatic int any_pos();
    return int'($urandom_range(0, 24'hFF_FFFF)) - 24'h80_0000;
  endfunction

  // Picks a slot that already holds a particle.
  function automatic int written_slot(input int lo, input int hi);
    int s;
    do s = $urandom_range(lo, hi); while (!written[s]);
    return s;
  endfunction

  initial begin
    int cx, cy, cz, span, n, r, radius, ref_d, gain, s;
    rst_n = 1'b0;
    start = 1'b0;
    in_opcode = 1'b0;
    in_slot = '0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    in_kind = '0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    loads_sent = 0;
    queries_sent = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: a tight cluster around the origin with a coincident
    // pair, a ghost, a kind-3 particle, a wall and one near the radius edge,
    // plus two particles at the corners of the position range.
    load_at(0, 0, 0, 0, 0);
    load_at(1, 10000, 0, 0, 1);
    load_at(2, 0, 0, 0, 0);
    load_at(3, 0, 20000, -5000, 2);
    load_at(4, -15000, 3000, 0, 3);
    load_at(5, 24'sh7F_FFFF, 24'sh7F_FFFF, 24'sh7F_FFFF, 0);
    load_at(6, -24'sh80_0000, -24'sh80_0000, -24'sh80_0000, 1);
    load_at(7, 40000, 0, 0, 0);
    load_at(1023, 5000, 5000, 5000, 0);
    drain();
    set_regs(Cluster, 32'h1_0000, 32'h1_2345, 8);
    for (int i = 0; i < 8; i++) query_at(i);
    query_at(1023);
    drain();
    // Coincident particles saturate the density; the full gain saturates
    // the pressure.
    set_regs(Cluster, 0, 32'hFFFF_FFFF, 8);
    query_at(0);
    query_at(2);
    drain();
    set_regs(0, 0, 32'hFFFF_FFFF, 8);
    query_at(1);
    drain();
    set_regs(23'h7F_FFFF, 24'hFF_FFFF, 32'h100, 8);
    query_at(5);
    query_at(6);
    drain();
    set_regs(Cluster, 0, 32'h100, 0);
    query_at(7);
    drain();

    // Random part: each phase changes the registers, makes sure every counted
    // slot holds a particle, reloads some of them as a cluster of random spread,
    // then mixes loads and queries.
    for (int ph = 0; ph < 29; ph++) begin
      r = $urandom_range(0, 9);
      radius = (r == 0) ? 0 : (r == 1) ? 23'h7F_FFFF :
               (r < 4) ? $urandom_range(1, 23'h7F_FFFF) : $urandom_range(2000, 200000);
      r = $urandom_range(0, 5);
      ref_d = (r == 0) ? 0 : (r == 1) ? 24'hFF_FFFF : $urandom_range(0, 24'h3F_FFFF);
      r = $urandom_range(0, 5);
      gain = (r == 0) ? 0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
      n = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 32) : $urandom_range(1, 16);
      cx = any_pos();
      cy = any_pos();
      cz = any_pos();
      span = (radius == 0) ? 1000 : radius / 2 + 1;
      if (span > 24'h7F_FFFF / 2) span = 24'h7F_FFFF / 2;
      drain();
      set_regs(radius, ref_d, gain, n);
      for (int k = 0; k < n; k++) begin
        if (!written[k] || $urandom_range(0, 2) == 0)
          load_at(k, near(cx, span), near(cy, span), near(cz, span), $urandom_range(0, 3));
      end
      for (int i = 0; i < 14; i++) begin
        r = $urandom_range(0, 9);
        if (r < 3) begin
          s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 31);
          if ($urandom_range(0, 5) == 0)
            load_at(s, any_pos(), any_pos(), any_pos(), $urandom_range(0, 3));
          else
            load_at(s, near(cx, span), near(cy, span), near(cz, span),
                    $urandom_range(0, 3));
        end else if (r < 9) begin
          query_at(written_slot(0, n - 1));
        end else begin
          query_at(written_slot(0, 1023));
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);

    $display("Sent %0d loads and %0d queries; %0d results were compared.",
             loads_sent, queries_sent, results_seen);
    $display("Registers swept zero, full-scale and random settings over clusters of all kinds.");
    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #80_000_000;
    $display("Timeout with %0d results outstanding.", pending);
    $display("CHECKS FAILED");
    $finish;
  end
endmodule

>>> filelist.f
design/pdp_pkg.sv
design/pdp_ctrl.sv
design/pdp_datapath.sv
design/particle_density_pressure_unit.sv
tb/sv/pdp_checker.sv
tb/sv/tb.sv
